[rtl/core/assert_macros.svh]
// assertion macros for the rtl files, used by the weight transform top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is high
`define ASSERT_ON_CLK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
  `ASSERT_ON_CLK(lbl, clk_s, rst_s, !(cond), msg)

`endif

[rtl/core/wft_pkg.sv]
// shared widths, coefficient matrix and pipeline control type of the weight transform
`timescale 1ns / 1ps

package wft_pkg;

  localparam int WEIGHT_BITS = 16;
  localparam int OUT_BITS    = WEIGHT_BITS + 1;
  localparam int COEF_FRAC   = 17;
  localparam int COEF_BITS   = COEF_FRAC + 2;
  localparam int ROUND_HALF  = 2 ** (COEF_FRAC - 1);

  // first pass: weight times coefficient, three terms summed
  localparam int PROD1_BITS  = WEIGHT_BITS + COEF_BITS;
  localparam int SUM1_BITS   = PROD1_BITS + 2;
  // intermediate values grow by at most the row-sum norm of g
  localparam int H_BITS      = WEIGHT_BITS + 2;
  // second pass
  localparam int PROD2_BITS  = H_BITS + COEF_BITS;
  localparam int SUM2_BITS   = PROD2_BITS + 2;

  localparam int TAPS        = 3;
  localparam int ROWS        = 8;
  localparam int ROW_BITS    = $clog2(ROWS);
  localparam logic [ROW_BITS-1:0] LAST_ROW = ROW_BITS'(ROWS - 1);

  // g of f(6,3) in q1.17
  localparam logic signed [COEF_BITS-1:0] G_MAT [ROWS][TAPS] = '{
    '{ 19'sd131072,       19'sd0,       19'sd0     },
    '{-19'sd29127,       -19'sd29127,  -19'sd29127 },
    '{-19'sd29127,        19'sd29127,  -19'sd29127 },
    '{ 19'sd1456,         19'sd2913,    19'sd5825  },
    '{ 19'sd1456,        -19'sd2913,    19'sd5825  },
    '{ 19'sd93207,        19'sd46603,   19'sd23302 },
    '{ 19'sd93207,       -19'sd46603,   19'sd23302 },
    '{ 19'sd0,            19'sd0,       19'sd131072}
  };

  typedef struct packed {
    logic                valid;
    logic [ROW_BITS-1:0] row_index;
    logic                row_last;
    logic                stream_last;
  } row_ctl_t;

endpackage

[rtl/core/wft_kernel_if.sv]
// kernel request channel: nine weights and the last-kernel mark
`timescale 1ns / 1ps

interface wft_kernel_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [wft_pkg::WEIGHT_BITS-1:0] weight_0;
  logic signed [wft_pkg::WEIGHT_BITS-1:0] weight_1;
  logic signed [wft_pkg::WEIGHT_BITS-1:0] weight_2;
  logic signed [wft_pkg::WEIGHT_BITS-1:0] weight_3;
  logic signed [wft_pkg::WEIGHT_BITS-1:0] weight_4;
  logic signed [wft_pkg::WEIGHT_BITS-1:0] weight_5;
  logic signed [wft_pkg::WEIGHT_BITS-1:0] weight_6;
  logic signed [wft_pkg::WEIGHT_BITS-1:0] weight_7;
  logic signed [wft_pkg::WEIGHT_BITS-1:0] weight_8;
  logic                                   kernel_last;

  modport source (
    output valid, weight_0, weight_1, weight_2, weight_3, weight_4,
           weight_5, weight_6, weight_7, weight_8, kernel_last,
    input  ready
  );
  modport sink (
    input  valid, weight_0, weight_1, weight_2, weight_3, weight_4,
           weight_5, weight_6, weight_7, weight_8, kernel_last,
    output ready
  );
endinterface

[rtl/core/wft_row_if.sv]
// tile row request channel: eight values, row number and last marks
`timescale 1ns / 1ps

interface wft_row_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [wft_pkg::OUT_BITS-1:0]    val_0;
  logic signed [wft_pkg::OUT_BITS-1:0]    val_1;
  logic signed [wft_pkg::OUT_BITS-1:0]    val_2;
  logic signed [wft_pkg::OUT_BITS-1:0]    val_3;
  logic signed [wft_pkg::OUT_BITS-1:0]    val_4;
  logic signed [wft_pkg::OUT_BITS-1:0]    val_5;
  logic signed [wft_pkg::OUT_BITS-1:0]    val_6;
  logic signed [wft_pkg::OUT_BITS-1:0]    val_7;
  logic [wft_pkg::ROW_BITS-1:0]           row_index;
  logic                                   row_last;
  logic                                   stream_last;

  modport source (
    output valid, val_0, val_1, val_2, val_3, val_4, val_5, val_6, val_7,
           row_index, row_last, stream_last,
    input  ready
  );
  modport sink (
    input  valid, val_0, val_1, val_2, val_3, val_4, val_5, val_6, val_7,
           row_index, row_last, stream_last,
    output ready
  );
endinterface

[rtl/core/wft_tile_row.sv]
// second transform pass: three intermediate values to one eight-value tile row
`timescale 1ns / 1ps

module wft_tile_row (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   adv,
  input  logic signed [wft_pkg::H_BITS-1:0]      h_in [wft_pkg::TAPS],
  input  wft_pkg::row_ctl_t                      ctl_in,
  output logic signed [wft_pkg::OUT_BITS-1:0]    vals [wft_pkg::ROWS],
  output wft_pkg::row_ctl_t                      ctl_out
);

  wft_pkg::row_ctl_t                          ctl_mul;
  logic signed [wft_pkg::PROD2_BITS-1:0]      prod [wft_pkg::ROWS][wft_pkg::TAPS];
  logic signed [wft_pkg::SUM2_BITS-1:0]       rnd  [wft_pkg::ROWS];

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_mul <= '0;
    end else if (adv) begin
      ctl_mul <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < wft_pkg::ROWS; i++) begin
        for (int r = 0; r < wft_pkg::TAPS; r++) begin
          prod[i][r] <= h_in[r] * wft_pkg::G_MAT[i][r];
        end
      end
    end
  end

  // sum and round to nearest, ties up
  always_comb begin
    for (int i = 0; i < wft_pkg::ROWS; i++) begin
      rnd[i] = wft_pkg::SUM2_BITS'(prod[i][0]) + wft_pkg::SUM2_BITS'(prod[i][1])
             + wft_pkg::SUM2_BITS'(prod[i][2])
             + wft_pkg::SUM2_BITS'(wft_pkg::ROUND_HALF);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out <= ctl_mul;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < wft_pkg::ROWS; i++) begin
        vals[i] <= rnd[i][wft_pkg::COEF_FRAC +: wft_pkg::OUT_BITS];
      end
    end
  end

endmodule

[rtl/core/winograd_f6x3_weight_transform_core.sv]
// top level of the winograd f(6x6,3x3) weight transform
`timescale 1ns / 1ps
`include "assert_macros.svh"

// winograd f(6x6,3x3) weight transform, t = g * k^t * g^t
// - kernels: one request carries a 3x3 kernel of q3.12 weights, row major,
//   and a mark for the final kernel of the channel set
// - rows: each kernel gives eight requests, tile rows 0 to 7 in order, of
//   eight q4.12 values each; row_last marks row 7, stream_last marks row 7
//   of the final kernel
// - throughput: one tile row per cycle while the output is not stalled; the
//   row sequencer issues one row of the held kernel into the pipe per cycle
//   and takes the next kernel in the cycle it issues row 7
// - pipeline: each issued row of a kernel passes the product, sum, product
//   and sum register stages in order
// - stall: while a row waits on the output, every stage and the sequencer
//   hold; nothing is lost or repeated, and a new kernel is still taken once
//   the held one has issued its last row
// - reset: clears the sequencer and all stage valid bits, no output pending
module winograd_f6x3_weight_transform_core (
  input  logic          clk,
  input  logic          rst,
  wft_kernel_if.sink    kernels,
  wft_row_if.source     rows
);

  // sequencer: held kernel and the row being issued
  logic                                   busy;
  logic [wft_pkg::ROW_BITS-1:0]           cnt;
  logic signed [wft_pkg::WEIGHT_BITS-1:0] kern [wft_pkg::TAPS][wft_pkg::TAPS];
  logic                                   kern_last;

  logic adv;      // whole pipe moves one step
  logic issue;    // a row enters the pipe
  logic take;     // kernel request accepted

  // first pass stages
  wft_pkg::row_ctl_t                      s1_ctl_next;
  wft_pkg::row_ctl_t                      s1_ctl;
  logic signed [wft_pkg::PROD1_BITS-1:0]  prod1 [wft_pkg::TAPS][wft_pkg::TAPS];
  logic signed [wft_pkg::SUM1_BITS-1:0]   rnd1  [wft_pkg::TAPS];
  wft_pkg::row_ctl_t                      s2_ctl;
  logic signed [wft_pkg::H_BITS-1:0]      h     [wft_pkg::TAPS];

  // output stage
  wft_pkg::row_ctl_t                      out_ctl;
  logic signed [wft_pkg::OUT_BITS-1:0]    vals  [wft_pkg::ROWS];

  assign adv   = !out_ctl.valid || rows.ready;
  assign issue = busy && adv;
  // free slot, or the held kernel issues its last row now
  assign kernels.ready = !busy || (cnt == wft_pkg::LAST_ROW && adv);
  assign take  = kernels.valid && kernels.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (take) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (issue) begin
      cnt <= cnt + 1'b1;
      if (cnt == wft_pkg::LAST_ROW) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kern[0][0] <= kernels.weight_0;
      kern[0][1] <= kernels.weight_1;
      kern[0][2] <= kernels.weight_2;
      kern[1][0] <= kernels.weight_3;
      kern[1][1] <= kernels.weight_4;
      kern[1][2] <= kernels.weight_5;
      kern[2][0] <= kernels.weight_6;
      kern[2][1] <= kernels.weight_7;
      kern[2][2] <= kernels.weight_8;
      kern_last  <= kernels.kernel_last;
    end
  end

  always_comb begin
    s1_ctl_next.valid       = issue;
    s1_ctl_next.row_index   = cnt;
    s1_ctl_next.row_last    = (cnt == wft_pkg::LAST_ROW);
    s1_ctl_next.stream_last = kern_last && (cnt == wft_pkg::LAST_ROW);
  end

  // stage 1: g row selected by the issued row times each kernel row
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (adv) begin
      s1_ctl <= s1_ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < wft_pkg::TAPS; r++) begin
        for (int c = 0; c < wft_pkg::TAPS; c++) begin
          prod1[r][c] <= kern[r][c] * wft_pkg::G_MAT[cnt][c];
        end
      end
    end
  end

  // stage 2: sum and round, ties up
  always_comb begin
    for (int r = 0; r < wft_pkg::TAPS; r++) begin
      rnd1[r] = wft_pkg::SUM1_BITS'(prod1[r][0]) + wft_pkg::SUM1_BITS'(prod1[r][1])
              + wft_pkg::SUM1_BITS'(prod1[r][2])
              + wft_pkg::SUM1_BITS'(wft_pkg::ROUND_HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else if (adv) begin
      s2_ctl <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < wft_pkg::TAPS; r++) begin
        h[r] <= rnd1[r][wft_pkg::COEF_FRAC +: wft_pkg::H_BITS];
      end
    end
  end

  // stages 3 and 4: second pass into the output register
  wft_tile_row u_tile_row (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .h_in    (h),
    .ctl_in  (s2_ctl),
    .vals    (vals),
    .ctl_out (out_ctl)
  );

  assign rows.valid       = out_ctl.valid;
  assign rows.row_index   = out_ctl.row_index;
  assign rows.row_last    = out_ctl.row_last;
  assign rows.stream_last = out_ctl.stream_last;
  assign rows.val_0       = vals[0];
  assign rows.val_1       = vals[1];
  assign rows.val_2       = vals[2];
  assign rows.val_3       = vals[3];
  assign rows.val_4       = vals[4];
  assign rows.val_5       = vals[5];
  assign rows.val_6       = vals[6];
  assign rows.val_7       = vals[7];

  // a new kernel while one is held only when its last row goes out
  `ASSERT_ON_CLK(a_take_on_last_row, clk, rst,
    take && busy |-> cnt == wft_pkg::LAST_ROW && issue, "kernel taken mid tile")
  // the issued row number reaches stage 1 in the next cycle
  `ASSERT_ON_CLK(a_issue_row, clk, rst,
    issue |=> s1_ctl.valid && s1_ctl.row_index == $past(cnt), "stage 1 row mismatch")
  // row marks agree with the row number
  `ASSERT_ON_CLK(a_row_last, clk, rst,
    rows.valid |-> rows.row_last == (rows.row_index == wft_pkg::LAST_ROW),
    "row_last off row 7")
  `ASSERT_NEVER(a_stream_last, clk, rst,
    rows.valid && rows.stream_last && !rows.row_last, "stream_last without row_last")

endmodule
